>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the compensation block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle (or a sequence from it)
`define BSC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// condition must never hold
`define BSC_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

>>> src/bsc_pkg.sv
// ---------------------------------------------------------------------------
// bsc_pkg
// Types, constants and helpers for the barometric compensation pipeline.
// ---------------------------------------------------------------------------
package bsc_pkg;

  typedef enum logic [2:0] {
    CFG_T1    = 3'd0,
    CFG_T2    = 3'd1,
    CFG_T3    = 3'd2,
    CFG_P1    = 3'd3,
    CFG_P2_P3 = 3'd4,
    CFG_P4_P5 = 3'd5,
    CFG_P6_P7 = 3'd6,
    CFG_P8_P9 = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               divide_error;
  } result_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [31:0] p2_p3;
    logic [31:0] p4_p5;
    logic [31:0] p6_p7;
    logic [31:0] p8_p9;
  } cal_t;

  localparam logic [63:0] TFINE_OFFSET = 64'd128000;
  localparam logic [63:0] P_FULL_SCALE = 64'd1048576;
  localparam logic [63:0] NUM_SCALE    = 64'd3125;
  localparam logic [31:0] TEMP_ROUND   = 32'd128;
  localparam logic [63:0] P1_BIAS      = 64'd1 << 47;
  localparam int          P4_SHIFT     = 35;

  // register stages per section
  localparam int TEMP_LAT  = 5;
  localparam int PRE_LAT   = 9;
  localparam int DIV_LAT   = 66;
  localparam int POST_LAT  = 6;
  localparam int TOTAL_LAT = TEMP_LAT + PRE_LAT + DIV_LAT + POST_LAT;

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage

>>> src/bsc_mul64.sv
// ---------------------------------------------------------------------------
// bsc_mul64
// Two-stage low-64 product from three 32x32 partial products.
// ---------------------------------------------------------------------------
module bsc_mul64 (
  input  logic        clk,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] y
);

  logic [63:0] p_ll;
  logic [31:0] p_hl;
  logic [31:0] p_lh;

  always_ff @(posedge clk) begin
    p_ll <= 64'(a[31:0]) * 64'(b[31:0]);
    p_hl <= a[63:32] * b[31:0];
    p_lh <= a[31:0] * b[63:32];
    y    <= p_ll + {p_hl + p_lh, 32'd0};
  end

endmodule

>>> src/bsc_temp.sv
// ---------------------------------------------------------------------------
// bsc_temp
// Five-stage temperature front end; also seeds the pressure path.
// ---------------------------------------------------------------------------
module bsc_temp (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_vld,
  input  bsc_pkg::sample_t in_beat,
  input  bsc_pkg::cal_t    cal,
  output logic             out_vld,
  output logic [31:0]      temp,
  output logic [63:0]      v1,
  output logic [63:0]      pp
);

  logic [4:0]  vld;
  logic [31:0] a1, b1, m1, bb, v1t3, m2, tfine;
  logic [19:0] adc_p1, adc_p2, adc_p3, adc_p4;
  logic [31:0] t2x, t3x, bbs;

  assign t2x = {{16{cal.t2[15]}}, cal.t2};
  assign t3x = {{16{cal.t3[15]}}, cal.t3};
  assign bbs = 32'($signed(bb) >>> 12);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    a1     <= {15'd0, in_beat.raw_temperature[19:3]} - {15'd0, cal.t1, 1'b0};
    b1     <= {16'd0, in_beat.raw_temperature[19:4]} - {16'd0, cal.t1};
    adc_p1 <= in_beat.raw_pressure;
    m1     <= a1 * t2x;
    bb     <= b1 * b1;
    adc_p2 <= adc_p1;
    v1t3   <= 32'($signed(m1) >>> 11);
    m2     <= bbs * t3x;
    adc_p3 <= adc_p2;
    tfine  <= v1t3 + 32'($signed(m2) >>> 14);
    adc_p4 <= adc_p3;
    temp   <= 32'($signed({tfine[29:0], 2'b00} + tfine + bsc_pkg::TEMP_ROUND) >>> 8);
    v1     <= {{32{tfine[31]}}, tfine} - bsc_pkg::TFINE_OFFSET;
    pp     <= bsc_pkg::P_FULL_SCALE - {44'd0, adc_p4};
  end

  assign out_vld = vld[4];

endmodule

>>> src/bsc_div.sv
// ---------------------------------------------------------------------------
// bsc_div
// Signed 64-bit divider, one quotient bit per stage, truncating to zero.
// ---------------------------------------------------------------------------
module bsc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_vld,
  input  logic [63:0] num,
  input  logic [63:0] den,
  input  logic [31:0] in_temp,
  output logic        out_vld,
  output logic [63:0] quot,
  output logic        out_err,
  output logic [31:0] out_temp
);

  typedef struct packed {
    logic [63:0] r;
    logic [63:0] n;
    logic [63:0] d;
    logic        neg;
    logic        err;
    logic [31:0] temp;
  } dstage_t;

  dstage_t    st [0:64];
  logic [64:0] vld;

  function automatic dstage_t div_step(input dstage_t s);
    dstage_t     o;
    logic [64:0] t;
    o   = s;
    t   = {s.r, s.n[63]};
    o.n = {s.n[62:0], 1'b0};
    if (t >= {1'b0, s.d}) begin
      o.r    = 64'(t - {1'b0, s.d});
      o.n[0] = 1'b1;
    end else begin
      o.r = t[63:0];
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else begin
      vld     <= {vld[63:0], in_vld};
      out_vld <= vld[64];
    end
  end

  always_ff @(posedge clk) begin
    st[0].r    <= '0;
    st[0].n    <= num[63] ? 64'd0 - num : num;
    st[0].d    <= den[63] ? 64'd0 - den : den;
    st[0].neg  <= num[63] ^ den[63];
    st[0].err  <= (den == 64'd0);
    st[0].temp <= in_temp;
    for (int i = 0; i < 64; i++) begin
      st[i+1] <= div_step(st[i]);
    end
    quot     <= st[64].neg ? 64'd0 - st[64].n : st[64].n;
    out_err  <= st[64].err;
    out_temp <= st[64].temp;
  end

endmodule

>>> src/barometric_sensor_compensation.sv
// ---------------------------------------------------------------------------
// barometric_sensor_compensation
// Integer pressure/temperature compensation, fully pipelined.
// ---------------------------------------------------------------------------
// Throughput: one sample pair per cycle; the 64-stage bit-per-stage divider
//   sets the depth, each stage retiring one quotient bit.
// Reset: synchronous; clears all valid bits and the calibration words to 0.
// busy follows rst; the receiver cannot stall, so nothing ever holds back.
module barometric_sensor_compensation (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  bsc_pkg::sample_t  sample,
  output logic              done,
  output bsc_pkg::result_t  result,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_idx,
  input  logic [31:0]       cfg_wdata
);

  `include "assert_macros.svh"

  logic accept;
  bsc_pkg::cal_t cal;

  assign busy   = rst;
  assign accept = start && !busy;

  // calibration registers; the user must write them only while the pipe is empty; the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_we) begin
      case (bsc_pkg::cfg_idx_t'(cfg_idx))
        bsc_pkg::CFG_T1:    cal.t1    <= cfg_wdata[15:0];
        bsc_pkg::CFG_T2:    cal.t2    <= cfg_wdata[15:0];
        bsc_pkg::CFG_T3:    cal.t3    <= cfg_wdata[15:0];
        bsc_pkg::CFG_P1:    cal.p1    <= cfg_wdata[15:0];
        bsc_pkg::CFG_P2_P3: cal.p2_p3 <= cfg_wdata;
        bsc_pkg::CFG_P4_P5: cal.p4_p5 <= cfg_wdata;
        bsc_pkg::CFG_P6_P7: cal.p6_p7 <= cfg_wdata;
        bsc_pkg::CFG_P8_P9: cal.p8_p9 <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sign-extended pressure words
  logic [63:0] p2x, p3x, p4x, p5x, p6x, p7x, p8x, p9x;
  assign p2x = bsc_pkg::sx16(cal.p2_p3[15:0]);
  assign p3x = bsc_pkg::sx16(cal.p2_p3[31:16]);
  assign p4x = bsc_pkg::sx16(cal.p4_p5[15:0]);
  assign p5x = bsc_pkg::sx16(cal.p4_p5[31:16]);
  assign p6x = bsc_pkg::sx16(cal.p6_p7[15:0]);
  assign p7x = bsc_pkg::sx16(cal.p6_p7[31:16]);
  assign p8x = bsc_pkg::sx16(cal.p8_p9[15:0]);
  assign p9x = bsc_pkg::sx16(cal.p8_p9[31:16]);

  // ---- temperature front end (5 stages) ----
  logic        t_vld;
  logic [31:0] t_temp;
  logic [63:0] t_v1, t_pp;

  bsc_temp u_temp (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (accept),
    .in_beat (sample),
    .cal     (cal),
    .out_vld (t_vld),
    .temp    (t_temp),
    .v1      (t_v1),
    .pp      (t_pp)
  );

  // ---- divisor / dividend build (9 stages) ----
  // pre_* taps: index k holds the beat that sits in stage k
  logic        pre_vld  [1:9];
  logic [31:0] pre_temp [1:9];
  logic [63:0] pre_pp   [1:5];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= 9; k++) pre_vld[k] <= 1'b0;
    end else begin
      pre_vld[1] <= t_vld;
      for (int k = 2; k <= 9; k++) pre_vld[k] <= pre_vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    pre_temp[1] <= t_temp;
    for (int k = 2; k <= 9; k++) pre_temp[k] <= pre_temp[k-1];
    pre_pp[1] <= t_pp;
    for (int k = 2; k <= 5; k++) pre_pp[k] <= pre_pp[k-1];
  end

  // stage A: var1^2, var1*P5, var1*P2
  logic [63:0] sq, m_p5, m_p2;
  bsc_mul64 u_mul_sq (.clk(clk), .a(t_v1), .b(t_v1), .y(sq));
  bsc_mul64 u_mul_p5 (.clk(clk), .a(t_v1), .b(p5x),  .y(m_p5));
  bsc_mul64 u_mul_p2 (.clk(clk), .a(t_v1), .b(p2x),  .y(m_p2));

  // stage B: var1^2 * P6, var1^2 * P3
  logic [63:0] m_p6, m_p3;
  logic [63:0] m_p5_d1, m_p5_d2, m_p2_d1, m_p2_d2;
  bsc_mul64 u_mul_p6 (.clk(clk), .a(sq), .b(p6x), .y(m_p6));
  bsc_mul64 u_mul_p3 (.clk(clk), .a(sq), .b(p3x), .y(m_p3));

  // stages C, D, F
  logic [63:0] v2, xb, nsub, xd, den, num;
  logic [63:0] m_p1, m_num;

  always_ff @(posedge clk) begin
    m_p5_d1 <= m_p5;
    m_p5_d2 <= m_p5_d1;
    m_p2_d1 <= m_p2;
    m_p2_d2 <= m_p2_d1;
    v2      <= m_p6 + (m_p5_d2 << 17) + (p4x << bsc_pkg::P4_SHIFT);
    xb      <= 64'($signed(m_p3) >>> 8) + (m_p2_d2 << 12) + bsc_pkg::P1_BIAS;
    nsub    <= (pre_pp[5] << 31) - v2;
    xd      <= xb;
    den     <= 64'($signed(m_p1) >>> 33);
    num     <= m_num;
  end

  // stage E: (bias + var1) * P1 and dividend * 3125
  bsc_mul64 u_mul_p1  (.clk(clk), .a(xd),   .b({48'd0, cal.p1}),  .y(m_p1));
  bsc_mul64 u_mul_num (.clk(clk), .a(nsub), .b(bsc_pkg::NUM_SCALE), .y(m_num));

  // ---- divider (66 stages) ----
  logic        d_vld, d_err;
  logic [63:0] d_q;
  logic [31:0] d_temp;

  bsc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (pre_vld[9]),
    .num      (num),
    .den      (den),
    .in_temp  (pre_temp[9]),
    .out_vld  (d_vld),
    .quot     (d_q),
    .out_err  (d_err),
    .out_temp (d_temp)
  );

  // ---- final correction (6 stages) ----
  logic        post_vld  [1:5];
  logic [31:0] post_temp [1:5];
  logic        post_err  [1:5];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= 5; k++) post_vld[k] <= 1'b0;
      done <= 1'b0;
    end else begin
      post_vld[1] <= d_vld;
      for (int k = 2; k <= 5; k++) post_vld[k] <= post_vld[k-1];
      done <= post_vld[5];
    end
  end

  logic [63:0] ps, ps_d1, ps_d2;
  logic [63:0] w1a, w1, w2, w2_d1, w2_d2;
  logic [63:0] q_d1, q_d2, q_d3, q_d4, psum, press;

  assign ps    = 64'($signed(d_q) >>> 13);
  assign press = 64'($signed(psum) >>> 8) + (p7x << 4);

  bsc_mul64 u_mul_p9 (.clk(clk), .a(ps),  .b(p9x),   .y(w1a));
  bsc_mul64 u_mul_p8 (.clk(clk), .a(d_q), .b(p8x),   .y(w2));
  bsc_mul64 u_mul_ps (.clk(clk), .a(w1a), .b(ps_d2), .y(w1));

  always_ff @(posedge clk) begin
    post_temp[1] <= d_temp;
    post_err[1]  <= d_err;
    for (int k = 2; k <= 5; k++) begin
      post_temp[k] <= post_temp[k-1];
      post_err[k]  <= post_err[k-1];
    end
    ps_d1 <= ps;
    ps_d2 <= ps_d1;
    q_d1  <= d_q;
    q_d2  <= q_d1;
    q_d3  <= q_d2;
    q_d4  <= q_d3;
    w2_d1 <= w2;
    w2_d2 <= w2_d1;
    psum  <= q_d4 + 64'($signed(w1) >>> 25) + 64'($signed(w2_d2) >>> 19);
    result.temperature_centi <= post_temp[5];
    result.pressure_q24_8    <= post_err[5] ? 32'd0 : press[31:0];
    result.divide_error      <= post_err[5];
  end

  // ---- checks ----
  `BSC_ASSERT_IMP(a_done_has_source, clk, rst, done, $past(accept, bsc_pkg::TOTAL_LAT))
  `BSC_ASSERT_IMP(a_accept_gives_done, clk, rst, accept, ##(bsc_pkg::TOTAL_LAT) done)
  `BSC_ASSERT_NEVER(a_err_zero_press, clk, rst, done && result.divide_error && (result.pressure_q24_8 != 32'd0))

endmodule

>>> sim/barometric_sensor_compensation_tb.sv
// ---------------------------------------------------------------------------
// barometric_sensor_compensation_tb
// Self-checking bench: drives sample pairs and calibration writes, predicts
// each compensated temperature/pressure result and checks it in order.
// ---------------------------------------------------------------------------
module barometric_sensor_compensation_tb;

  localparam int PIPE_DEPTH = 86;  // equals bsc_pkg::TOTAL_LAT, the pipeline depth

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  bsc_pkg::sample_t sample = '0;
  logic             done;
  bsc_pkg::result_t result;
  logic             cfg_we = 1'b0;
  logic [2:0]       cfg_idx = '0;
  logic [31:0]      cfg_wdata = '0;

  barometric_sensor_compensation u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sample(sample),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // calibration words as the bench believes them to be
  logic [15:0] cw_t1, cw_t2, cw_t3, cw_p1;
  logic [31:0] cw_p23, cw_p45, cw_p67, cw_p89;

  bsc_pkg::sample_t pending_samples[$];
  bsc_pkg::result_t expected_results[$];
  int      n_errors = 0;
  bit      quiet_tail = 1'b0;   // no idling in the last part of the run
  int      gap_left = 0;

  function automatic logic [63:0] asr64(logic [63:0] x, int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] asr32(logic [31:0] x, int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] sext16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // compensation arithmetic: 32-bit wrapping temperature, 64-bit pressure
  function automatic bsc_pkg::result_t compensate(bsc_pkg::sample_t s);
    bsc_pkg::result_t r;
    logic [31:0] t1, t2, t3, a, b, v1t, v2t, tfine, temp;
    logic [63:0] p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, ps, w1, w2, an, ad, q;
    bit nn, dn;
    t1 = {16'd0, cw_t1};
    t2 = {{16{cw_t2[15]}}, cw_t2};
    t3 = {{16{cw_t3[15]}}, cw_t3};
    a = {15'd0, s.raw_temperature[19:3]} - (t1 << 1);
    v1t = asr32(a * t2, 11);
    b = {16'd0, s.raw_temperature[19:4]} - t1;
    v2t = asr32(asr32(b * b, 12) * t3, 14);
    tfine = v1t + v2t;
    temp = asr32(tfine * 32'd5 + 32'd128, 8);

    p2 = sext16(cw_p23[15:0]); p3 = sext16(cw_p23[31:16]);
    p4 = sext16(cw_p45[15:0]); p5 = sext16(cw_p45[31:16]);
    p6 = sext16(cw_p67[15:0]); p7 = sext16(cw_p67[31:16]);
    p8 = sext16(cw_p89[15:0]); p9 = sext16(cw_p89[31:16]);
    v1 = {{32{tfine[31]}}, tfine} - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = asr64(((64'd1 << 47) + v1) * {48'd0, cw_p1}, 33);

    r.temperature_centi = temp;
    if (v1 == 64'd0) begin
      r.pressure_q24_8 = '0;
      r.divide_error = 1'b1;
    end else begin
      p = 64'd1048576 - {44'd0, s.raw_pressure};
      p = ((p << 31) - v2) * 64'd3125;
      // signed divide, truncating toward zero, done on magnitudes
      nn = p[63]; dn = v1[63];
      an = nn ? -p : p;
      ad = dn ? -v1 : v1;
      q = an / ad;
      p = (nn != dn) ? -q : q;
      ps = asr64(p, 13);
      w1 = asr64(p9 * ps * ps, 25);
      w2 = asr64(p8 * p, 19);
      p = asr64(p + w1 + w2, 8) + (p7 << 4);
      r.pressure_q24_8 = p[31:0];
      r.divide_error = 1'b0;
    end
    return r;
  endfunction

  // driver: one beat per accepted start, random idle bursts between
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(compensate(sample));
      end
      if (start && busy) begin
        // held until taken
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_samples.size() > 0 && (quiet_tail || $urandom_range(5) != 0)) begin
        sample <= pending_samples.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
        if (!quiet_tail && pending_samples.size() > 0) gap_left <= $urandom_range(3);
      end
    end
  end

  // monitor: every done strobe is one result beat
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: temperature_centi %0d", result.temperature_centi);
        n_errors++;
      end else begin
        bsc_pkg::result_t e;
        e = expected_results.pop_front();
        if (result.temperature_centi !== e.temperature_centi) begin
          $error("temperature_centi exp %0d got %0d", e.temperature_centi,
                 result.temperature_centi);
          n_errors++;
        end
        if (result.pressure_q24_8 !== e.pressure_q24_8) begin
          $error("pressure_q24_8 exp %h got %h", e.pressure_q24_8, result.pressure_q24_8);
          n_errors++;
        end
        if (result.divide_error !== e.divide_error) begin
          $error("divide_error exp %b got %b", e.divide_error, result.divide_error);
          n_errors++;
        end
      end
    end
  end

  task automatic write_cal(bsc_pkg::cfg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      bsc_pkg::CFG_T1:    cw_t1 = val[15:0];
      bsc_pkg::CFG_T2:    cw_t2 = val[15:0];
      bsc_pkg::CFG_T3:    cw_t3 = val[15:0];
      bsc_pkg::CFG_P1:    cw_p1 = val[15:0];
      bsc_pkg::CFG_P2_P3: cw_p23 = val;
      bsc_pkg::CFG_P4_P5: cw_p45 = val;
      bsc_pkg::CFG_P6_P7: cw_p67 = val;
      bsc_pkg::CFG_P8_P9: cw_p89 = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until the pipe has drained
  task automatic drain();
    while (pending_samples.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_cal(logic [15:0] t1, t2, t3, p1, logic [31:0] p23, p45, p67, p89);
    write_cal(bsc_pkg::CFG_T1, {16'd0, t1});
    write_cal(bsc_pkg::CFG_T2, {16'd0, t2});
    write_cal(bsc_pkg::CFG_T3, {16'd0, t3});
    write_cal(bsc_pkg::CFG_P1, {16'd0, p1});
    write_cal(bsc_pkg::CFG_P2_P3, p23);   write_cal(bsc_pkg::CFG_P4_P5, p45);
    write_cal(bsc_pkg::CFG_P6_P7, p67);   write_cal(bsc_pkg::CFG_P8_P9, p89);
  endtask

  function automatic bsc_pkg::sample_t rand_sample();
    bsc_pkg::sample_t s;
    s.raw_pressure = 20'($urandom());
    s.raw_temperature = 20'($urandom());
    return s;
  endfunction

  initial begin
    bsc_pkg::sample_t s;
    cw_t1 = '0; cw_t2 = '0; cw_t3 = '0; cw_p1 = '0;
    cw_p23 = '0; cw_p45 = '0; cw_p67 = '0; cw_p89 = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset calibration: p1 is zero, so every beat is a divide error
    s = '0; pending_samples.push_back(s);
    s = '1; pending_samples.push_back(s);
    drain();

    // typical factory words, extremes of the raw fields
    load_cal(16'd27504, 16'd26435, -16'sd1000, 16'd36477,
             {-16'sd12, -16'sd10685}, {16'd140, 16'd2855},
             {16'd15500, -16'sd7}, {16'd6000, -16'sd14600});
    pending_samples.push_back('{20'd0, 20'd0});
    pending_samples.push_back('{20'hFFFFF, 20'hFFFFF});
    pending_samples.push_back('{20'hFFFFF, 20'd0});
    pending_samples.push_back('{20'd0, 20'hFFFFF});
    pending_samples.push_back('{20'd415148, 20'd519888});
    pending_samples.push_back('{20'h55555, 20'hAAAAA});
    pending_samples.push_back('{20'hAAAAA, 20'h55555});
    drain();

    // all-ones, most-positive and most-negative words
    load_cal(16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF, 32'h7FFF8000, 32'h80007FFF,
             32'hFFFFFFFF, 32'h80008000);
    repeat (8) pending_samples.push_back(rand_sample());
    drain();

    // random phases: plausible words mostly, full random now and then
    for (int ph = 0; ph < 10; ph++) begin
      if (ph % 3 == 2)
        load_cal(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                 $urandom(), $urandom(), $urandom(), $urandom());
      else
        load_cal(16'($urandom_range(20000, 32000)), 16'($urandom_range(20000, 30000)),
                 -16'($urandom_range(0, 2000)),
                 (ph == 4) ? 16'd0 : 16'($urandom_range(30000, 40000)),
                 {-16'($urandom_range(0, 50)), -16'($urandom_range(5000, 12000))},
                 {16'($urandom_range(0, 400)), 16'($urandom_range(2000, 9000))},
                 {-16'($urandom_range(0, 20)), 16'($urandom_range(0, 20000))},
                 {16'($urandom_range(0, 8000)), -16'($urandom_range(0, 20000))});
      if (ph == 9) quiet_tail = 1'b1;
      repeat (110) pending_samples.push_back(rand_sample());
      drain();
    end

    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (n_errors == 0)
      $display("barometric_sensor_compensation_tb: done, clean");
    else
      $display("barometric_sensor_compensation_tb: done, errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("barometric_sensor_compensation_tb: done, errors");
    $finish;
  end
endmodule

>>> sim.f
+incdir+src
src/bsc_pkg.sv
src/bsc_mul64.sv
src/bsc_temp.sv
src/bsc_div.sv
src/barometric_sensor_compensation.sv
sim/barometric_sensor_compensation_tb.sv
